// ===== rtl/core/sha256_stream_hasher_top_macros.svh =====
// Assertion helpers for the hasher.
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH

// Implication checked on every edge outside reset.
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked with a non-overlapping (|=>) consequent.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sha256_pkg.sv =====
package sha256_pkg;

	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QPtrW = $clog2(QueueDepth);

	// One queued beat after the front end has classified it.
	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       eom;
	} sha_item_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} sha_state_t;

	localparam logic [31:0] InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== rtl/core/sha256_front.sv =====
module sha256_front
	import sha256_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [9:0]      in_data,
	output logic            q_valid,
	input  logic            q_pop,
	output sha_item_t       q_item
);

	sha_item_t            mem_q [QueueDepth];
	logic [QPtrW-1:0]     wr_q, rd_q;
	logic [QPtrW:0]       cnt_q;
	logic                 push;

	// Items with neither byte nor end do nothing: drop them here.
	assign in_ready = (cnt_q != (QPtrW+1)'(QueueDepth));
	assign push     = in_valid && in_ready && (in_data[8] || in_data[9]);
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{data: in_data[7:0], has_byte: in_data[8], eom: in_data[9]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPtrW+1)'(push) - (QPtrW+1)'(q_pop);
		end
	end

endmodule

// ===== rtl/core/sha256_back.sv =====
module sha256_back
	import sha256_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_pop,
	input  sha_item_t       q_item,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [31:0]     out_word,
	output logic [2:0]      out_index,
	output logic            out_last,
	output logic            busy
);

	sha_state_t   state_q, state_d;
	logic [31:0]  w_q [16];
	logic [31:0]  h_q [8];
	logic [31:0]  v_q [8];
	logic [5:0]   fill_q;
	logic [5:0]   rnd_q;
	logic [60:0]  len_q;
	logic         fin_q;
	logic [2:0]   emit_q;
	logic         mark_q;
	// A finishing message needs another padded block when the length did not fit.
	logic         extra_q;

	logic         take, blk_full, rnd_done;
	logic [7:0]   pad_byte;
	logic [7:0]   wr_byte;
	logic         wr_en;
	logic [31:0]  w_new, t1, t2, w_cur;
	logic [63:0]  bits;

	assign bits     = {len_q, 3'b000};
	assign take     = (state_q == ST_LOAD) && q_valid;
	assign q_pop    = take;
	assign rnd_done = (rnd_q == 6'd63);
	assign busy     = (state_q != ST_LOAD);

	// Padding byte: 0x80 first, zeros, then the length in bytes 56..63 of the last block.
	always_comb begin
		priority if (!mark_q) pad_byte = 8'h80;
		else if (fill_q >= 6'd56 && !extra_q) pad_byte = bits[8*(63 - fill_q) +: 8];
		else pad_byte = 8'h00;
	end

	assign wr_en   = take ? q_item.has_byte : (state_q == ST_PAD);
	assign wr_byte = take ? q_item.data : pad_byte;
	assign blk_full = wr_en && (fill_q == 6'd63);

	always_comb begin
		w_cur = w_q[0];
		w_new = w_q[0] + (ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3))
		      + w_q[9] + (ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10));
		t1 = v_q[7] + (ror32(v_q[4], 6) ^ ror32(v_q[4], 11) ^ ror32(v_q[4], 25))
		   + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[rnd_q] + w_cur;
		t2 = (ror32(v_q[0], 2) ^ ror32(v_q[0], 13) ^ ror32(v_q[0], 22))
		   + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (take) begin
					if (blk_full) state_d = ST_ROUND;
					else if (q_item.eom) state_d = ST_PAD;
				end
			end
			ST_PAD:   if (fill_q == 6'd63) state_d = ST_ROUND;
			ST_ROUND: if (rnd_done) state_d = ST_FOLD;
			ST_FOLD:  state_d = fin_q ? ((!mark_q || extra_q) ? ST_PAD : ST_EMIT) : ST_LOAD;
			ST_EMIT:  if (out_ready && emit_q == 3'd7) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		out_valid = (state_q == ST_EMIT);
		out_word  = h_q[emit_q];
		out_index = emit_q;
		out_last  = (emit_q == 3'd7);
	end

	always_ff @(posedge clk) begin
		if (wr_en) w_q[fill_q[5:2]][8*(3 - fill_q[1:0]) +: 8] <= wr_byte;
		if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			for (int i = 1; i < 8; i++) v_q[i] <= v_q[i-1];
			v_q[4] <= v_q[3] + t1;
			v_q[0] <= t1 + t2;
		end else begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
			fill_q  <= '0;
			rnd_q   <= '0;
			len_q   <= '0;
			fin_q   <= 1'b0;
			emit_q  <= '0;
			mark_q  <= 1'b0;
			extra_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) fill_q <= fill_q + 6'd1;
			if (take) begin
				if (q_item.has_byte) len_q <= len_q + 61'd1;
				if (q_item.eom) fin_q <= 1'b1;
			end
			if (state_q == ST_PAD && !mark_q) begin
				// Length goes in a further block when the 0x80 lands past byte 55.
				mark_q  <= 1'b1;
				extra_q <= (fill_q >= 6'd56);
			end
			if (state_q == ST_ROUND) rnd_q <= rnd_q + 6'd1;
			if (state_q == ST_FOLD) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				extra_q <= 1'b0;
			end
			if (state_q == ST_EMIT && out_ready) begin
				emit_q <= emit_q + 3'd1;
				if (emit_q == 3'd7) begin
					for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
					fill_q <= '0;
					len_q  <= '0;
					fin_q  <= 1'b0;
					mark_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== rtl/core/sha256_stream_hasher_top.sv =====
// SHA-256 over a byte stream. Each accepted beat may carry one byte and may end the
// message; after the end beat the eight digest words come out, word 0 first, tlast on
// the eighth. Beats with neither byte nor end are dropped. Beats enter a four-deep queue
// at one per cycle while it has room; the back end absorbs one byte a cycle while loading,
// then runs each block through the rounds on the single shared round unit and a fold
// step, taking no bytes meanwhile. An end beat costs one padding write per byte up to the
// block end, rounds and a fold per padded block (one or two blocks), then eight output beats.
module sha256_stream_hasher_top
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // data_byte[7:0], has_byte[8], end_of_message[9]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // digest_word[31:0], word_index[34:32]
	output logic        m_axis_tlast
);
	`include "sha256_stream_hasher_top_macros.svh"

	logic       q_valid, q_pop, busy;
	sha_item_t  q_item;
	logic [31:0] word;
	logic [2:0]  idx;

	sha256_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata[9:0]),
		.q_valid, .q_pop, .q_item
	);

	sha256_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_item,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_word(word), .out_index(idx), .out_last(m_axis_tlast), .busy
	);

	assign m_axis_tdata = {5'd0, idx, word};

	`SHA_ASSERT_IMP(a_pop_valid, q_pop, q_valid, "pop from empty queue")
	`SHA_ASSERT_IMP(a_last_idx, m_axis_tvalid && m_axis_tlast, idx == 3'd7, "tlast off word 7")
	`SHA_ASSERT_IMP(a_no_pop_busy, busy, !q_pop, "pop while busy")
	`SHA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat dropped while stalled")

endmodule
